@@ rtl/ihex_pkg.sv @@
// shared types, constants and the hex digit decoder of the hex record receiver
`default_nettype none

package ihex_pkg;

  localparam int LINE_LIMIT  = 520;
  localparam int DATA_DEPTH  = 256;
  localparam int DATA_IDX_W  = $clog2(DATA_DEPTH);
  localparam int MIN_LINE    = 11;
  localparam int DATA_OFFSET = 4;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  localparam logic [7:0] KIND_DATA = 8'h00;
  localparam logic [7:0] KIND_END  = 8'h01;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_SUM,
    ST_IDX,
    ST_INC,
    ST_JLEN,
    ST_JCMP,
    ST_DRD,
    ST_DWR,
    ST_EOF
  } state_t;

  // request to the shared adder: a + b, or a - b when sub is set
  typedef struct packed {
    logic [10:0] a;
    logic [10:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] data_word;
    logic [3:0]  bytes_valid;
    logic        last_of_record;
    logic        end_of_file;
  } emit_t;

  // returns {digit_ok, digit_value}; value is zero for a bad digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    logic       ok;
    t  = 8'h00;
    ok = 1'b1;
    if (c inside {[CH_0:CH_9]}) begin
      t = c - CH_0;
    end else if (c inside {[CH_UA:CH_UF]}) begin
      t = c - CH_UA + 8'd10;
    end else if (c inside {[CH_LA:CH_LF_HEX]}) begin
      t = c - CH_LA + 8'd10;
    end else begin
      ok = 1'b0;
    end
    return {ok, t[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/ihex_if.sv @@
// handshake channels for received characters and record results
`default_nettype none

interface ihex_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ihex_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  bytes_valid;
  logic        last_of_record;
  logic        end_of_file;

  modport source (output valid, output data_word, output bytes_valid,
                  output last_of_record, output end_of_file, input ready);
  modport sink (input valid, input data_word, input bytes_valid,
                input last_of_record, input end_of_file, output ready);
endinterface

`default_nettype wire

@@ rtl/ihex_alu.sv @@
// shared add/subtract unit used by the steps of the sequencer
`default_nettype none

module ihex_alu (
  input  ihex_pkg::alu_req_t req,
  output logic [11:0]        res
);

  logic [11:0] b_ext;

  always_comb begin
    b_ext = req.sub ? {1'b0, ~req.b} : {1'b0, req.b};
    // bit 11 is the carry: for a subtraction it means no borrow
    res = {1'b0, req.a} + b_ext + {11'd0, req.sub};
  end

endmodule

`default_nettype wire

@@ rtl/ihex_seq.sv @@
// character sequencer: line parsing, data byte store and result packing
`default_nettype none

module ihex_seq (
  input  logic                     clk,
  input  logic                     rst,
  ihex_rx_if.sink                  rx,
  input  logic                     out_free,
  output ihex_pkg::emit_t          emit,
  output ihex_pkg::alu_req_t       alu_req,
  input  logic [11:0]              alu_res
);

  localparam logic signed [10:0] DIFF_LIMIT = 11'(ihex_pkg::DATA_OFFSET);
  localparam logic [8:0]         DEPTH_W    = 9'(ihex_pkg::DATA_DEPTH);

  ihex_pkg::state_t state, state_next;

  logic [9:0]  pos;
  logic [3:0]  hnib;
  logic [7:0]  rsum;
  logic [7:0]  rlen;
  logic [7:0]  rkind;
  logic        rej;
  logic        fin;
  logic [7:0]  chr;
  logic [10:0] diff;
  logic [7:0]  val;
  logic [9:0]  lim;
  logic [8:0]  idx;
  logic [63:0] word;
  logic [7:0]  rdata;

  logic [7:0]  mem [ihex_pkg::DATA_DEPTH];

  logic [9:0]  pos_m1;
  logic [8:0]  bidx;
  logic [4:0]  dig;
  logic        skip;
  logic        in_data;
  logic [8:0]  mlen;
  logic [63:0] word_cur;
  logic        last_byte;
  logic        need;
  logic        line_ok;
  logic        clear_line;

  always_comb begin
    pos_m1    = pos - 10'd1;
    bidx      = pos_m1[9:1];
    dig       = ihex_pkg::hex_digit(chr);
    skip      = $signed(alu_res[10:0]) > DIFF_LIMIT;
    in_data   = (bidx >= 9'(ihex_pkg::DATA_OFFSET)) && ($signed(diff) < DIFF_LIMIT);
    mlen      = ({1'b0, rlen} > DEPTH_W) ? DEPTH_W : {1'b0, rlen};
    word_cur  = word;
    word_cur[idx[2:0]*8 +: 8] = rdata;
    last_byte = (alu_res[8:0] == mlen);
    need      = last_byte || (idx[2:0] == 3'd7);
    line_ok   = alu_res[11] && !rej && (rsum == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihex_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    rx.ready    = 1'b0;
    alu_req     = '0;
    emit        = '0;
    clear_line  = 1'b0;
    case (state)
      ihex_pkg::ST_IDLE: begin
        rx.ready = 1'b1;
        if (rx.valid && !fin) begin
          if (rx.rx_byte == ihex_pkg::CH_LF) begin
            if (pos != 10'd0) state_next = ihex_pkg::ST_JLEN;
          end else if (rx.rx_byte != ihex_pkg::CH_CR) begin
            state_next = ihex_pkg::ST_CHK;
          end
        end
      end
      ihex_pkg::ST_CHK: begin
        alu_req.a   = {2'b00, bidx};
        alu_req.b   = {3'b000, rlen};
        alu_req.sub = 1'b1;
        if (pos == 10'd0 || skip || pos[0]) begin
          state_next = ihex_pkg::ST_INC;
        end else begin
          state_next = ihex_pkg::ST_SUM;
        end
      end
      ihex_pkg::ST_SUM: begin
        alu_req.a = {3'b000, rsum};
        alu_req.b = {3'b000, val};
        state_next = in_data ? ihex_pkg::ST_IDX : ihex_pkg::ST_INC;
      end
      ihex_pkg::ST_IDX: begin
        alu_req.a   = {2'b00, bidx};
        alu_req.b   = 11'(ihex_pkg::DATA_OFFSET);
        alu_req.sub = 1'b1;
        state_next  = ihex_pkg::ST_INC;
      end
      ihex_pkg::ST_INC: begin
        alu_req.a = {1'b0, pos};
        alu_req.b = 11'd1;
        if (alu_res[9:0] >= 10'(ihex_pkg::LINE_LIMIT - 1)) begin
          state_next = ihex_pkg::ST_JLEN;
        end else begin
          state_next = ihex_pkg::ST_IDLE;
        end
      end
      ihex_pkg::ST_JLEN: begin
        alu_req.a  = {2'b00, rlen, 1'b0};
        alu_req.b  = 11'(ihex_pkg::MIN_LINE);
        state_next = ihex_pkg::ST_JCMP;
      end
      ihex_pkg::ST_JCMP: begin
        // minimum line length covers header, data and checksum
        alu_req.a   = {1'b0, pos};
        alu_req.b   = {1'b0, lim};
        alu_req.sub = 1'b1;
        if (line_ok && rkind == ihex_pkg::KIND_DATA && rlen != 8'd0) begin
          state_next = ihex_pkg::ST_DRD;
        end else if (line_ok && rkind == ihex_pkg::KIND_END) begin
          state_next = ihex_pkg::ST_EOF;
        end else begin
          clear_line = 1'b1;
          state_next = ihex_pkg::ST_IDLE;
        end
      end
      ihex_pkg::ST_DRD: begin
        state_next = ihex_pkg::ST_DWR;
      end
      ihex_pkg::ST_DWR: begin
        alu_req.a = {2'b00, idx};
        alu_req.b = 11'd1;
        if (!need || out_free) begin
          emit.valid          = need;
          emit.data_word      = word_cur;
          emit.bytes_valid    = {1'b0, idx[2:0]} + 4'd1;
          emit.last_of_record = last_byte;
          if (last_byte) begin
            clear_line = 1'b1;
            state_next = ihex_pkg::ST_IDLE;
          end else begin
            state_next = ihex_pkg::ST_DRD;
          end
        end
      end
      ihex_pkg::ST_EOF: begin
        if (out_free) begin
          emit.valid          = 1'b1;
          emit.last_of_record = 1'b1;
          emit.end_of_file    = 1'b1;
          clear_line          = 1'b1;
          state_next          = ihex_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ihex_pkg::ST_IDLE;
      end
    endcase
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst || clear_line) begin
      pos   <= '0;
      hnib  <= '0;
      rsum  <= '0;
      rlen  <= '0;
      rkind <= '0;
      rej   <= 1'b0;
    end else begin
      case (state)
        ihex_pkg::ST_CHK: begin
          if (pos == 10'd0) begin
            if (chr != ihex_pkg::CH_COLON) rej <= 1'b1;
          end else if (!skip) begin
            if (!dig[4]) rej <= 1'b1;
            if (pos[0]) hnib <= dig[3:0];
          end
        end
        ihex_pkg::ST_SUM: begin
          rsum <= alu_res[7:0];
          if (bidx == 9'd0) rlen <= val;
          if (bidx == 9'd3) rkind <= val;
        end
        ihex_pkg::ST_INC: begin
          pos <= alu_res[9:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else if (state == ihex_pkg::ST_EOF && out_free) begin
      fin <= 1'b1;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ihex_pkg::ST_IDLE: begin
        chr <= rx.rx_byte;
      end
      ihex_pkg::ST_CHK: begin
        diff <= alu_res[10:0];
        val  <= {hnib, dig[3:0]};
      end
      ihex_pkg::ST_JLEN: begin
        lim <= alu_res[9:0];
      end
      ihex_pkg::ST_JCMP: begin
        idx  <= '0;
        word <= '0;
      end
      ihex_pkg::ST_DWR: begin
        if (!need || out_free) begin
          idx  <= alu_res[8:0];
          word <= need ? 64'd0 : word_cur;
        end
      end
      default: begin
      end
    endcase
  end

  // data byte store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (state == ihex_pkg::ST_IDX &&
        alu_res[10:0] < 11'(ihex_pkg::DATA_DEPTH)) begin
      mem[alu_res[ihex_pkg::DATA_IDX_W-1:0]] <= val;
    end
    if (state == ihex_pkg::ST_DRD) begin
      rdata <= mem[idx[ihex_pkg::DATA_IDX_W-1:0]];
    end
  end

endmodule

`default_nettype wire

@@ rtl/intel_hex_record_receiver_unit.sv @@
// top level of the hex record receiver: sequencer, shared adder and output register
`default_nettype none

// Takes one ASCII character per item and parses lines as hex records
// (colon, length, address, type, data, checksum; hex digits of either case).
// Carriage returns are ignored; a line ends at a newline or when it holds
// 519 characters. Valid type 00 records of nonzero length come out as 64-bit
// words of up to eight data bytes, first byte lowest; a valid type 01 record gives one end
// item and all later input is ignored. The steps of the sequencer share a
// single adder, and the input is not ready while a character is handled.
// After a line is judged, its data bytes are read back from the byte store
// one at a time and packed into words; a full output register stalls this.
// The byte store needs no clearing pass after reset.
module intel_hex_record_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  ihex_rx_if.sink     rx,
  ihex_res_if.source  res
);

  ihex_pkg::alu_req_t alu_req;
  logic [11:0]        alu_res;
  ihex_pkg::emit_t    emit;
  logic               out_valid;
  logic               out_free;

  assign out_free = !out_valid || res.ready;

  ihex_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  ihex_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .out_free (out_free),
    .emit     (emit),
    .alu_req  (alu_req),
    .alu_res  (alu_res)
  );

  // output register parts the sequencer from the result consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      res.data_word      <= emit.data_word;
      res.bytes_valid    <= emit.bytes_valid;
      res.last_of_record <= emit.last_of_record;
      res.end_of_file    <= emit.end_of_file;
    end
  end

  assign res.valid = out_valid;

  a_ready_not_emit: assert property (@(posedge clk) disable iff (rst)
    !(rx.ready && emit.valid))
    else $error("input ready while a result is produced");

  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.end_of_file |-> res.bytes_valid == 4'd0 && res.last_of_record)
    else $error("end item carries data");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.end_of_file |-> res.bytes_valid != 4'd0 && res.bytes_valid <= 4'd8)
    else $error("data item byte count out of range");

  a_quiet_after_eof: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && res.end_of_file |=> !emit.valid && !out_valid)
    else $error("result after end item");

endmodule

`default_nettype wire
